// ===== rtl/rmq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// Types and constants for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int ONE_Q14   = 16384;
    localparam int SQ_STEPS  = 18;   // root bits of a 35-bit radicand
    localparam int DIV_STEPS = 24;   // quotient bits of a 33-bit dividend
    localparam int NUM_DIVS  = 3;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

    // Square-root section: argument, numerators and partial root.
    typedef struct packed {
        branch_t               br;
        logic                  bad;
        logic [16:0]           arg;
        logic [2:0][17:0]      n;
        logic [19:0]           rem;
        logic [17:0]           res;
    } sq_t;

    // Division section: three long divisions by the root in parallel.
    typedef struct packed {
        branch_t               br;
        logic                  bad;
        logic [15:0]           root;
        logic [17:0]           r;
        logic [2:0]            neg;
        logic [2:0][32:0]      num;
        logic [2:0][17:0]      rem;
        logic [2:0][23:0]      q;
    } dv_t;

endpackage

`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 1 front stage, 18 square-root stages, 1 prep stage, 24 division
// stages and 1 output stage between input request and result.
// Throughput: one matrix per cycle; the whole pipeline holds only while a result
// is waiting with m_tready low.
// Reset: aresetn clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a Q2.14 rotation matrix to a saturated Q2.14
// quaternion, with bit-serial square root and three pipelined dividers.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [143:0] s_tdata,  // m00,m01,m02,m10,m11,m12,m20,m21,m22
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic [2:0]        m_tuser   // branch_taken[1:0], bad_input
);
    import rmq_pkg::*;

    localparam int NST = SQ_STEPS + DIV_STEPS + 3;

    logic             ce;
    logic [NST-1:0]   vld_reg;

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // ---------------- front stage: branch select and numerators ----------
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [17:0] trace;
    logic signed [18:0] arg;
    logic signed [17:0] d_w, d_y, d_z, s_xy, s_xz, s_yz;
    sq_t                front_next;
    sq_t                sq_reg [0:SQ_STEPS];

    assign m00 = s_tdata[15:0];
    assign m01 = s_tdata[31:16];
    assign m02 = s_tdata[47:32];
    assign m10 = s_tdata[63:48];
    assign m11 = s_tdata[79:64];
    assign m12 = s_tdata[95:80];
    assign m20 = s_tdata[111:96];
    assign m21 = s_tdata[127:112];
    assign m22 = s_tdata[143:128];

    assign d_w  = 18'(m21) - 18'(m12);
    assign d_y  = 18'(m02) - 18'(m20);
    assign d_z  = 18'(m10) - 18'(m01);
    assign s_xy = 18'(m01) + 18'(m10);
    assign s_xz = 18'(m02) + 18'(m20);
    assign s_yz = 18'(m12) + 18'(m21);
    assign trace = 18'(m00) + 18'(m11) + 18'(m22);

    always_comb begin
        front_next     = '0;
        if (trace > 18'sd0) begin
            front_next.br = BR_TRACE;
            arg           = 19'(ONE_Q14) + 19'(trace);
            front_next.n  = {d_z, d_y, d_w};
        end else if (m00 > m11 && m00 > m22) begin
            front_next.br = BR_X;
            arg           = 19'(ONE_Q14) + 19'(m00) - 19'(m11) - 19'(m22);
            front_next.n  = {s_xz, s_xy, d_w};
        end else if (m11 > m22) begin
            front_next.br = BR_Y;
            arg           = 19'(ONE_Q14) + 19'(m11) - 19'(m00) - 19'(m22);
            front_next.n  = {s_yz, s_xy, d_y};
        end else begin
            front_next.br = BR_Z;
            arg           = 19'(ONE_Q14) + 19'(m22) - 19'(m00) - 19'(m11);
            front_next.n  = {s_yz, s_xz, d_z};
        end
        front_next.bad = (arg <= 19'sd0);
        front_next.arg = front_next.bad ? 17'd0 : arg[16:0];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sq_reg[0] <= front_next;
        end
    end

    // ---------------- square root, one result bit per stage ---------------
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam int PI = SQ_STEPS - 1 - k;
        logic [35:0] rad;
        logic [21:0] rem_sh;
        logic [21:0] trial;
        sq_t         nxt;

        assign rad    = {1'b0, sq_reg[k].arg, 18'd0};
        assign rem_sh = {sq_reg[k].rem, rad[2*PI+1 -: 2]};
        assign trial  = {2'b00, sq_reg[k].res, 2'b01};

        always_comb begin
            nxt = sq_reg[k];
            if (rem_sh >= trial) begin
                nxt.rem = 20'(rem_sh - trial);
                nxt.res = {sq_reg[k].res[16:0], 1'b1};
            end else begin
                nxt.rem = rem_sh[19:0];
                nxt.res = {sq_reg[k].res[16:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                sq_reg[k+1] <= nxt;
            end
        end
    end

    // ---------------- prep: rounded root and dividends --------------------
    dv_t        prep_next;
    dv_t        dv_reg [0:DIV_STEPS];
    logic [18:0] root_sum;

    assign root_sum = {1'b0, sq_reg[SQ_STEPS].res} + 19'd4;

    always_comb begin
        logic signed [17:0] nv;
        logic [16:0]        mag;
        prep_next      = '0;
        prep_next.br   = sq_reg[SQ_STEPS].br;
        prep_next.bad  = sq_reg[SQ_STEPS].bad;
        prep_next.r    = sq_reg[SQ_STEPS].res;
        prep_next.root = root_sum[18:3];
        for (int i = 0; i < NUM_DIVS; i++) begin
            nv                = sq_reg[SQ_STEPS].n[i];
            mag               = nv[17] ? 17'(-nv) : nv[16:0];
            prep_next.neg[i]  = nv[17];
            prep_next.num[i]  = {1'b0, mag, 15'd0} + 33'(sq_reg[SQ_STEPS].res[17:1]);
            prep_next.rem[i]  = {9'd0, prep_next.num[i][32:24]};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dv_reg[0] <= prep_next;
        end
    end

    // ---------------- long division, one quotient bit per stage -----------
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int BI = DIV_STEPS - 1 - j;
        dv_t nxt;

        always_comb begin
            logic [18:0] t;
            nxt = dv_reg[j];
            for (int i = 0; i < NUM_DIVS; i++) begin
                t = {dv_reg[j].rem[i], dv_reg[j].num[i][BI]};
                if (t >= {1'b0, dv_reg[j].r}) begin
                    nxt.rem[i] = 18'(t - {1'b0, dv_reg[j].r});
                    nxt.q[i]   = {dv_reg[j].q[i][22:0], 1'b1};
                end else begin
                    nxt.rem[i] = t[17:0];
                    nxt.q[i]   = {dv_reg[j].q[i][22:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                dv_reg[j+1] <= nxt;
            end
        end
    end

    // ---------------- output: sign, saturate, place components ------------
    logic [2:0][15:0] sv;
    logic [15:0]      qw, qx, qy, qz;
    logic [63:0]      tdata_reg;
    logic [2:0]       tuser_reg;

    always_comb begin
        for (int i = 0; i < NUM_DIVS; i++) begin
            if (dv_reg[DIV_STEPS].neg[i]) begin
                sv[i] = (dv_reg[DIV_STEPS].q[i] >= 24'd32768) ? 16'h8000
                      : 16'(-dv_reg[DIV_STEPS].q[i]);
            end else begin
                sv[i] = (dv_reg[DIV_STEPS].q[i] >= 24'd32768) ? 16'h7fff
                      : dv_reg[DIV_STEPS].q[i][15:0];
            end
        end
        unique case (dv_reg[DIV_STEPS].br)
            BR_TRACE: begin
                qw = dv_reg[DIV_STEPS].root; qx = sv[0]; qy = sv[1]; qz = sv[2];
            end
            BR_X: begin
                qw = sv[0]; qx = dv_reg[DIV_STEPS].root; qy = sv[1]; qz = sv[2];
            end
            BR_Y: begin
                qw = sv[0]; qx = sv[1]; qy = dv_reg[DIV_STEPS].root; qz = sv[2];
            end
            default: begin
                qw = sv[0]; qx = sv[1]; qy = sv[2]; qz = dv_reg[DIV_STEPS].root;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            tdata_reg <= dv_reg[DIV_STEPS].bad ? 64'd0 : {qz, qy, qx, qw};
            tuser_reg <= {dv_reg[DIV_STEPS].bad, dv_reg[DIV_STEPS].br};
        end
    end

    assign m_tdata = tdata_reg;
    assign m_tuser = tuser_reg;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion testbench
// Streams Q2.14 matrices into the converter and checks every quaternion,
// branch code and bad-input flag against a bit-exact integer predictor or a typed row.
// A directed table covers extremes, all branches, diagonal ties and diagonal-only
// matrices; random ones follow, mostly bounded entries, with some raw noise.
// ----------------------------------------------------------------------------
module tb;
    import rmq_pkg::*;

    localparam int LATENCY    = 45;
    localparam int N_RANDOM   = 1800;
    localparam int WATCHDOG   = 20000;
    localparam int CALM_TAIL  = 300;

    typedef struct {
        logic signed [15:0] m [9];
        logic               known;
        logic [15:0]        w, x, y, z;
        branch_t            br;
        logic               bad;
    } mat_row_t;

    typedef struct {
        logic [15:0] w, x, y, z;
        branch_t     br;
        logic        bad;
    } quat_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;

    quat_t  pending_quats [$];
    int     mismatches;
    int     results_seen;
    int     idle_cycles;
    int     sent;
    bit     calm;
    bit     long_hold;
    int     branch_hits [4];
    int     bad_hits;

    rotation_matrix_to_quaternion dut (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] clip16(longint v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    // n * 2^15 / r rounded to nearest, ties away from zero.
    function automatic logic [15:0] scaled_quotient(longint n, longint unsigned r);
        longint unsigned mag;
        longint q;
        mag = (n < 0 ? -n : n) << 15;
        q = longint'((mag + (r >> 1)) / r);
        return clip16(n < 0 ? -q : q);
    endfunction

    function automatic quat_t shepperd_quat(logic signed [15:0] m [9]);
        quat_t q;
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, arg;
        longint unsigned r;
        logic [15:0] root;
        a00 = m[0]; a01 = m[1]; a02 = m[2];
        a10 = m[3]; a11 = m[4]; a12 = m[5];
        a20 = m[6]; a21 = m[7]; a22 = m[8];
        tr = a00 + a11 + a22;
        if (tr > 0) begin
            q.br = BR_TRACE; arg = ONE_Q14 + tr;
        end else if (a00 > a11 && a00 > a22) begin
            q.br = BR_X; arg = ONE_Q14 + a00 - a11 - a22;
        end else if (a11 > a22) begin
            q.br = BR_Y; arg = ONE_Q14 + a11 - a00 - a22;
        end else begin
            q.br = BR_Z; arg = ONE_Q14 + a22 - a00 - a11;
        end
        q.w = '0; q.x = '0; q.y = '0; q.z = '0;
        q.bad = (arg <= 0);
        if (!q.bad) begin
            r = int_sqrt(longint'(arg) << 18);
            root = clip16(longint'((r + 4) >> 3));
            case (q.br)
                BR_TRACE: begin
                    q.w = root;
                    q.x = scaled_quotient(a21 - a12, r);
                    q.y = scaled_quotient(a02 - a20, r);
                    q.z = scaled_quotient(a10 - a01, r);
                end
                BR_X: begin
                    q.w = scaled_quotient(a21 - a12, r);
                    q.x = root;
                    q.y = scaled_quotient(a01 + a10, r);
                    q.z = scaled_quotient(a02 + a20, r);
                end
                BR_Y: begin
                    q.w = scaled_quotient(a02 - a20, r);
                    q.x = scaled_quotient(a01 + a10, r);
                    q.y = root;
                    q.z = scaled_quotient(a12 + a21, r);
                end
                default: begin
                    q.w = scaled_quotient(a10 - a01, r);
                    q.x = scaled_quotient(a02 + a20, r);
                    q.y = scaled_quotient(a12 + a21, r);
                    q.z = root;
                end
            endcase
        end
        return q;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Sends one matrix, holding valid across back-to-back requests.
    task automatic send_matrix(logic signed [15:0] m [9], bit known, quat_t typed);
        quat_t q;
        int gap;
        q = shepperd_quat(m);
        if (known) q = typed;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        for (int i = 0; i < 9; i++) s_tdata[16*i +: 16] <= m[i];
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_quats = {pending_quats, q};
        sent++;
    endtask

    task automatic pause_sender();
        s_tvalid <= 1'b0;
        while (pending_quats.size() != 0) @(posedge aclk);
    endtask

    function automatic mat_row_t row(int v0, int v1, int v2, int v3, int v4,
                                     int v5, int v6, int v7, int v8);
        mat_row_t r;
        r.m = '{16'(v0), 16'(v1), 16'(v2), 16'(v3), 16'(v4),
                16'(v5), 16'(v6), 16'(v7), 16'(v8)};
        r.known = 1'b0;
        return r;
    endfunction

    function automatic mat_row_t typed_row(mat_row_t r, int w, int x, int y,
                                           int z, branch_t br, logic bad);
        r.known = 1'b1;
        r.w = 16'(w); r.x = 16'(x); r.y = 16'(y); r.z = 16'(z);
        r.br = br; r.bad = bad;
        return r;
    endfunction

    // Random matrix: bounded entries with a steered diagonal, or raw noise.
    function automatic void random_matrix(ref logic signed [15:0] m [9]);
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            for (int i = 0; i < 9; i++)
                m[i] = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
            // Push one diagonal entry high or all low to spread the branches.
            case ($urandom_range(0, 4))
                0: m[0] = 16'($urandom_range(8000, 16384));
                1: m[4] = 16'($urandom_range(8000, 16384));
                2: m[8] = 16'($urandom_range(8000, 16384));
                3: begin
                    m[0] = 16'($urandom_range(0, 4000)) - 16'sd16384;
                    m[4] = 16'($urandom_range(0, 4000)) - 16'sd16384;
                    m[8] = 16'($urandom_range(0, 4000)) - 16'sd16384;
                end
                default: ;
            endcase
        end else begin
            for (int i = 0; i < 9; i++) m[i] = 16'($urandom);
        end
    endfunction

    mat_row_t directed [$];

    initial begin
        logic signed [15:0] m [9];
        quat_t none;
        none.w = '0; none.x = '0; none.y = '0; none.z = '0;
        none.br = BR_TRACE; none.bad = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        mismatches = 0;
        sent = 0;
        calm = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Identity: w = 1.0, branch on the trace.
        directed = {directed, typed_row(row(16384, 0, 0, 0, 16384, 0, 0, 0, 16384),
                                        16384, 0, 0, 0, BR_TRACE, 1'b0)};
        // 180 degrees about each axis.
        directed = {directed, typed_row(row(16384, 0, 0, 0, -16384, 0, 0, 0, -16384),
                                        0, 16384, 0, 0, BR_X, 1'b0)};
        directed = {directed, typed_row(row(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384),
                                        0, 0, 16384, 0, BR_Y, 1'b0)};
        directed = {directed, typed_row(row(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384),
                                        0, 0, 0, 16384, BR_Z, 1'b0)};
        // Zero matrix: trace zero, tie on the diagonal falls to m22, z = 0.5.
        directed = {directed, typed_row(row(0, 0, 0, 0, 0, 0, 0, 0, 0),
                                        0, 0, 0, 8192, BR_Z, 1'b0)};
        // Diagonal-only matrices that select each diagonal branch.
        directed = {directed, row(-32768, 0, 0, 0, -32768, 0, 0, 0, 32767)};
        directed = {directed, row(-20000, 0, 0, 0, 10000, 0, 0, 0, 10000)};
        directed = {directed, row(-8000, 0, 0, 0, -7000, 0, 0, 0, -9000)};
        directed = {directed, row(0, 0, 0, 0, -20000, 0, 0, 0, -20000)};
        // Ties: m00 equal to m11, m11 equal to m22.
        directed = {directed, row(-5000, 100, 200, 300, -5000, 400, 500, 600, -9000)};
        directed = {directed, row(-9000, 100, 200, 300, -5000, 400, 500, 600, -5000)};
        // Extremes: full-scale entries everywhere and mixed-sign full-scale entries.
        directed = {directed, row(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                  32767, 32767)};
        directed = {directed, row(-32768, -32768, -32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768)};
        directed = {directed, row(1, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0)};
        directed = {directed, row(-32768, 32767, 32767, 32767, -32768, 32767, -32768,
                                  -32768, -16384)};
        directed = {directed, row(-16384, 32767, -32768, -32768, 16384, 32767, 32767,
                                  -32768, -16384)};
        directed = {directed, row(16384, -32768, -32768, 32767, -16384, -32768, 32767,
                                  32767, -16384)};
        directed = {directed, row(-1, 0, 0, 0, -1, 0, 0, 0, 1)};
        directed = {directed, row(11585, -11585, 0, 11585, 11585, 0, 0, 0, 16384)};

        foreach (directed[i]) begin
            quat_t t;
            t.w = directed[i].w; t.x = directed[i].x; t.y = directed[i].y;
            t.z = directed[i].z; t.br = directed[i].br; t.bad = directed[i].bad;
            send_matrix(directed[i].m, directed[i].known, directed[i].known ? t : none);
        end
        pause_sender();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) pause_sender();
            if (i == N_RANDOM - CALM_TAIL) calm = 1'b1;
            random_matrix(m);
            send_matrix(m, 1'b0, none);
        end
        s_tvalid <= 1'b0;
        while (pending_quats.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);

        $display("Sent %0d matrices, %0d results; branches %0d/%0d/%0d/%0d, bad input %0d.",
                 sent, results_seen, branch_hits[0], branch_hits[1], branch_hits[2],
                 branch_hits[3], bad_hits);
        $display("Covered extremes, diagonal ties, saturation and stalls on both sides.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off, none at the end.
    initial begin
        int burst;
        m_tready = 1'b0;
        long_hold = 1'b0;
        @(posedge aresetn);
        forever begin
            if (!long_hold && sent > 600) begin
                long_hold = 1'b1;
                m_tready <= 1'b0;
                repeat (150) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 13);
                m_tready <= 1'b0;
                repeat (burst) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Checker and watchdog.
    always @(posedge aclk) begin
        quat_t want;
        if (!aresetn) begin
            idle_cycles <= 0;
            results_seen <= 0;
            bad_hits <= 0;
            branch_hits <= '{0, 0, 0, 0};
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("Timeout after %0d idle cycles", idle_cycles);
                $display("Mismatches found");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (pending_quats.size() == 0) begin
                    $display("[%0t] result with no request outstanding", $realtime);
                    mismatches++;
                end else begin
                    want = pending_quats.pop_front();
                    branch_hits[want.br] <= branch_hits[want.br] + 1;
                    if (want.bad) bad_hits <= bad_hits + 1;
                    if (m_tdata[15:0] !== want.w)
                        report_mismatch("quat_w", m_tdata[15:0], want.w);
                    if (m_tdata[31:16] !== want.x)
                        report_mismatch("quat_x", m_tdata[31:16], want.x);
                    if (m_tdata[47:32] !== want.y)
                        report_mismatch("quat_y", m_tdata[47:32], want.y);
                    if (m_tdata[63:48] !== want.z)
                        report_mismatch("quat_z", m_tdata[63:48], want.z);
                    if (m_tuser[1:0] !== want.br)
                        report_mismatch("branch_taken", 16'(m_tuser[1:0]), 16'(want.br));
                    if (m_tuser[2] !== want.bad)
                        report_mismatch("bad_input", 16'(m_tuser[2]), 16'(want.bad));
                end
            end
        end
    end

endmodule

// ===== files.f =====
rtl/rmq_pkg.sv
rtl/rotation_matrix_to_quaternion.sv
test/tb.sv
